/* rtl/b58enc_pkg.sv */
// Shared constants, types and functions of the base-58 digit encoder.
`default_nettype none

package b58enc_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int IN_W           = 32;
	localparam int CHAR_W         = 7;
	localparam int DIGIT_W        = 6;
	localparam int RADIX          = 58;
	localparam int CHUNK_W        = 16;

	// x / 58 == (x * RECIP) >> RECIP_SHIFT for every x < 58 * 2^16
	localparam int PROD_IN_W     = DIGIT_W + CHUNK_W;
	localparam int RECIP_W       = 23;
	localparam int RECIP_SHIFT   = 28;
	localparam logic [RECIP_W-1:0] RECIP = 23'd4628198;
	localparam int PROD_W        = PROD_IN_W + RECIP_W;

	localparam logic [8*RADIX-1:0] ALPHABET =
		"123456789abcdefghijkmnopqrstuvwxyzABCDEFGHJKLMNPQRSTUVWXYZ";

	typedef struct packed {
		logic load;
		logic step;
		logic first;
		logic push;
		logic pop;
	} b58enc_cmd_t;

	typedef struct packed {
		logic quot_zero;
		logic last_digit;
		logic out_free;
	} b58enc_status_t;

	// Number of base-58 digits of the largest value of the given width.
	function automatic int b58_max_digits(input int bits);
		longint top;
		longint p;
		int     n;
		top = (longint'(1) <<< bits) - 1;
		p   = RADIX;
		n   = 1;
		for (int i = 0; i < 12; i++) begin
			if (p <= top) begin
				n++;
				p = p * RADIX;
			end
		end
		return n;
	endfunction

	function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
		int idx;
		idx = int'(d);
		if (idx >= RADIX)
			idx = 0;
		return CHAR_W'(ALPHABET[8*(RADIX-1-idx) +: 8]);
	endfunction

endpackage

`default_nettype wire

/* rtl/b58enc_datapath.sv */
// Datapath: chunked divide by 58, digit stack and output register.
`default_nettype none

module b58enc_datapath
	import b58enc_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [IN_W-1:0]     value,
	input  wire b58enc_cmd_t         cmd,
	output b58enc_status_t           status,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [CHAR_W-1:0]        character,
	output logic                     last
);

	localparam int Chunks    = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;
	localparam int QuotW     = Chunks * CHUNK_W;
	localparam int MaxDigits = b58_max_digits(VALUE_BITS);
	localparam int IdxW      = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;
	localparam int DepW      = $clog2(MaxDigits + 1);

	logic [QuotW-1:0]   quot_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [DIGIT_W-1:0] dig_q [MaxDigits];
	logic [DepW-1:0]    depth_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic [DIGIT_W-1:0]       rem_in;
	logic [PROD_IN_W-1:0]     dividend;
	logic [PROD_W-1:0]        prod;
	logic [CHUNK_W-1:0]       q_chunk;
	logic [PROD_IN_W-1:0]     rem_full;
	logic [DIGIT_W-1:0]       rem_next;
	logic [QuotW+CHUNK_W-1:0] quot_shift;
	logic [QuotW-1:0]         quot_next;
	logic [DepW-1:0]          depth_dec;
	logic [IdxW-1:0]          pop_idx;
	logic                     out_free;

	assign rem_in   = cmd.first ? '0 : rem_q;
	assign dividend = {rem_in, quot_q[QuotW-1 -: CHUNK_W]};
	assign prod     = PROD_W'(dividend) * PROD_W'(RECIP);
	assign q_chunk  = prod[RECIP_SHIFT +: CHUNK_W];
	// 58 = 32 + 16 + 8 + 2
	assign rem_full = dividend - ((PROD_IN_W'(q_chunk) << 5) + (PROD_IN_W'(q_chunk) << 4)
		+ (PROD_IN_W'(q_chunk) << 3) + (PROD_IN_W'(q_chunk) << 1));
	assign rem_next   = rem_full[DIGIT_W-1:0];
	assign quot_shift = {quot_q, q_chunk};
	assign quot_next  = quot_shift[QuotW-1:0];

	assign depth_dec = depth_q - DepW'(1);
	assign pop_idx   = depth_dec[IdxW-1:0];
	assign out_free  = !out_valid_q || !out_stall;

	assign status.quot_zero  = (quot_next == '0);
	assign status.last_digit = (depth_q == DepW'(1));
	assign status.out_free   = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push)
				depth_q <= depth_q + DepW'(1);
			else if (cmd.pop)
				depth_q <= depth_dec;
			if (cmd.pop)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			quot_q <= QuotW'(value[VALUE_BITS-1:0]);
		else if (cmd.step)
			quot_q <= quot_next;
		if (cmd.step)
			rem_q <= rem_next;
		if (cmd.push)
			dig_q[depth_q[IdxW-1:0]] <= rem_next;
		if (cmd.pop) begin
			char_q <= b58_char(dig_q[pop_idx]);
			last_q <= (depth_q == DepW'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> depth_q != '0)
		else $error("digit stack popped while empty");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> depth_q < DepW'(MaxDigits))
		else $error("digit stack overflow");

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> depth_q == '0)
		else $error("new value loaded with digits pending");

	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> out_free)
		else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

/* rtl/b58enc_ctrl.sv */
// Controller: sequences load, divide steps and character pops.
`default_nettype none

module b58enc_ctrl
	import b58enc_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire b58enc_status_t status,
	output b58enc_cmd_t         cmd
);

	localparam int Chunks = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;
	localparam int CntW   = (Chunks > 1) ? $clog2(Chunks) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	state_t          state_q;
	logic [CntW-1:0] chunk_cnt_q;
	logic            last_chunk;

	assign last_chunk = (chunk_cnt_q == CntW'(Chunks - 1));
	assign in_stall   = (state_q != ST_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.load  = (state_q == ST_IDLE) && in_valid;
		cmd.step  = (state_q == ST_DIVIDE);
		cmd.first = (state_q == ST_DIVIDE) && (chunk_cnt_q == '0);
		cmd.push  = (state_q == ST_DIVIDE) && last_chunk;
		cmd.pop   = (state_q == ST_EMIT) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chunk_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					chunk_cnt_q <= '0;
					if (in_valid)
						state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (last_chunk) begin
						chunk_cnt_q <= '0;
						if (status.quot_zero)
							state_q <= ST_EMIT;
					end else begin
						chunk_cnt_q <= chunk_cnt_q + CntW'(1);
					end
				end
				ST_EMIT: begin
					// drop back once the least significant digit has gone out
					if (status.out_free && status.last_digit)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && in_valid |=> in_stall)
		else $error("accepted a transaction without going busy");

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> chunk_cnt_q == '0)
		else $error("chunk counter not cleared after divide");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.step && !cmd.pop)
		else $error("load overlaps divide or pop");

endmodule

`default_nettype wire

/* rtl/base58_digit_encoder_core.sv */
// Top level of the base-58 digit encoder: controller plus datapath.
//
//  channel | direction | handshake           | payload
//  in      | sink      | in_valid / in_stall | value[31:0]
//  out     | source    | out_valid/out_stall | character[6:0], last
//
// Each digit takes one divide step per 16-bit chunk of the value (two for 32 bits),
// each step one 22x23 reciprocal multiply; the digit count d is 1..6 for 32 bits.
// A value occupies the block through its division and its output; the next value
// is taken after the last character has been loaded into the output register.
// The output register is one transaction deep: a stall on out holds it and pauses
// the character pops. Reset clears the state machine, stack depth and out_valid.
`default_nettype none

module base58_digit_encoder_core
	import b58enc_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [IN_W-1:0]   value,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [CHAR_W-1:0]      character,
	output logic                   last
);

	b58enc_cmd_t    cmd;
	b58enc_status_t status;

	b58enc_ctrl #(
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	b58enc_datapath #(
		.VALUE_BITS(VALUE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

endmodule

`default_nettype wire
